@@ rtl/hsad_pkg.sv @@
// Shared types, constants and the sector table of the Hall sector angle decoder.
package hsad_pkg;

    localparam int ANGLE_W = 16;
    localparam int CODE_W  = 3;

    localparam logic signed [ANGLE_W-1:0] DIR_THRESHOLD = 16'sd1820;
    localparam logic signed [ANGLE_W-1:0] COUNT_LIMIT   = 16'sd32767;
    localparam logic signed [ANGLE_W-1:0] SENSE_LIMIT   = 16'sd2;

    localparam logic [CODE_W-1:0] HALL_LOGIC_FAULT  = 3'd0;
    localparam logic [CODE_W-1:0] HALL_WIRING_FAULT = 3'd7;

    typedef enum logic [1:0] {
        CFG_DECODE_ENABLE    = 2'd0,
        CFG_INVERT_DIRECTION = 2'd1,
        CFG_FAULT_ENABLE     = 2'd2,
        CFG_ZERO_OFFSET      = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        FAULT_NONE    = 2'd0,
        FAULT_WIRING  = 2'd1,
        FAULT_LOGIC   = 2'd2
    } fault_t;

    typedef enum logic [1:0] {
        SENSE_UNKNOWN  = 2'd0,
        SENSE_FORWARD  = 2'd1,
        SENSE_BACKWARD = 2'd2
    } sense_t;

    typedef struct packed {
        logic               decode_enable;
        logic               invert_direction;
        logic               fault_enable;
        logic [ANGLE_W-1:0] zero_offset;
    } cfg_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] electrical_angle;
        logic [ANGLE_W-1:0] corrected_angle;
        sense_t             rotation_sense;
        fault_t             fault_code;
    } result_t;

    function automatic logic [ANGLE_W-1:0] sector_angle(input logic [CODE_W-1:0] code);
        logic [ANGLE_W-1:0] angle;
        case (code)
            3'd1:    angle = 16'd60074;
            3'd2:    angle = 16'd38229;
            3'd3:    angle = 16'd49152;
            3'd4:    angle = 16'd16384;
            3'd5:    angle = 16'd5461;
            3'd6:    angle = 16'd27306;
            default: angle = '0;
        endcase
        return angle;
    endfunction

endpackage

@@ rtl/hsad_if.sv @@
// Handshake channel interfaces for Hall samples, results and configuration writes.
interface hsad_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] hall_code;
    logic       motor_running;

    modport source (output valid, output hall_code, output motor_running, input ready);
    modport sink   (input valid, input hall_code, input motor_running, output ready);
endinterface

interface hsad_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] electrical_angle;
    logic [15:0] corrected_angle;
    logic [1:0]  rotation_sense;
    logic [1:0]  fault_code;

    modport source (output valid, output electrical_angle, output corrected_angle,
                    output rotation_sense, output fault_code, input ready);
    modport sink   (input valid, input electrical_angle, input corrected_angle,
                    input rotation_sense, input fault_code, output ready);
endinterface

interface hsad_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [15:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

@@ rtl/hsad_cfg_regs.sv @@
// Configuration register file of the Hall sector angle decoder.
module hsad_cfg_regs
    import hsad_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [1:0]   wr_index,
    input  logic [15:0]  wr_data,
    output cfg_t         cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                CFG_DECODE_ENABLE:    cfg_next.decode_enable    = wr_data[0];
                CFG_INVERT_DIRECTION: cfg_next.invert_direction = wr_data[0];
                CFG_FAULT_ENABLE:     cfg_next.fault_enable     = wr_data[0];
                CFG_ZERO_OFFSET:      cfg_next.zero_offset      = wr_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/hsad_step.sv @@
// Angle decode and direction tracking state with its per-sample next-state logic.
module hsad_step
    import hsad_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                go,
    input  logic [CODE_W-1:0]   hall_code,
    input  logic                motor_running,
    output result_t             res
);

    logic [ANGLE_W-1:0]        held_reg, held_next;
    logic [ANGLE_W-1:0]        out_angle_reg, out_angle_next;
    logic [ANGLE_W-1:0]        ref_reg, ref_next;
    logic signed [ANGLE_W-1:0] count_reg, count_next;
    logic signed [ANGLE_W-1:0] delta;
    logic                      code_valid;
    fault_t                    fault;
    sense_t                    sense;

    assign code_valid = (hall_code != HALL_LOGIC_FAULT) && (hall_code != HALL_WIRING_FAULT);

    always_comb
    begin
        held_next      = held_reg;
        out_angle_next = out_angle_reg;
        fault          = FAULT_NONE;
        if (cfg.decode_enable)
        begin
            if (code_valid)
                held_next = sector_angle(hall_code);
            else if (motor_running && cfg.fault_enable)
                fault = (hall_code == HALL_WIRING_FAULT) ? FAULT_WIRING : FAULT_LOGIC;
            out_angle_next = cfg.invert_direction ? (ANGLE_W'(0) - held_next) : held_next;
        end
    end

    assign delta = $signed(out_angle_next - ref_reg);

    always_comb
    begin
        count_next = count_reg;
        ref_next   = ref_reg;
        if (delta > DIR_THRESHOLD)
        begin
            if (count_reg < COUNT_LIMIT)
                count_next = count_reg + 16'sd1;
            ref_next = out_angle_next;
        end
        else if (delta < -DIR_THRESHOLD)
        begin
            if (count_reg > -COUNT_LIMIT)
                count_next = count_reg - 16'sd1;
            ref_next = out_angle_next;
        end
    end

    always_comb
    begin
        if (count_next > SENSE_LIMIT)
            sense = SENSE_FORWARD;
        else if (count_next < -SENSE_LIMIT)
            sense = SENSE_BACKWARD;
        else
            sense = SENSE_UNKNOWN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            out_angle_reg <= '0;
            ref_reg       <= '0;
            count_reg     <= '0;
        end
        else if (go)
        begin
            held_reg      <= held_next;
            out_angle_reg <= out_angle_next;
            ref_reg       <= ref_next;
            count_reg     <= count_next;
        end
    end

    always_comb
    begin
        res.electrical_angle = out_angle_next;
        res.corrected_angle  = out_angle_next + cfg.zero_offset;
        res.rotation_sense   = sense;
        res.fault_code       = fault;
    end

endmodule

@@ rtl/hall_sector_angle_direction.sv @@
// Hall sector angle and rotation-sense decoder, top level.
// Each accepted 3-bit Hall sample produces exactly one result: the Q16 sector
// angle (held over invalid codes, negated when inverted), the angle plus the
// zero offset, the rotation sense from a saturating step counter, and a fault
// code for codes 0 and 7 while running with decoding and faults enabled. A sample is
// registered on transfer into the input register, decoded against the tracking
// state once the result register is free and written to the result register.
// One sample per cycle is sustained while results are taken; the input
// register and the result register are the two stages, and a stalled result
// holds only the stages behind it. Configuration writes are always ready and
// must be made while no sample is in flight.
module hall_sector_angle_direction
    import hsad_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    hsad_in_if.sink     sample,
    hsad_out_if.source  result,
    hsad_cfg_if.sink    cfg
);

    cfg_t              cfg_q;
    result_t           step_res;
    result_t           result_reg;
    logic              result_valid_reg;
    logic              s1_valid_reg;
    logic [CODE_W-1:0] s1_code_reg;
    logic              s1_running_reg;
    logic              result_free;
    logic              advance;

    assign cfg.ready   = 1'b1;
    assign result_free = !result_valid_reg || result.ready;
    assign advance     = s1_valid_reg && result_free;
    assign sample.ready = !s1_valid_reg || result_free;

    hsad_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid && cfg.ready),
        .wr_index (cfg.reg_index),
        .wr_data  (cfg.wdata),
        .cfg      (cfg_q)
    );

    hsad_step u_step (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_q),
        .go            (advance),
        .hall_code     (s1_code_reg),
        .motor_running (s1_running_reg),
        .res           (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample.ready)
                s1_valid_reg <= sample.valid;
            if (result_free)
                result_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            s1_code_reg    <= sample.hall_code;
            s1_running_reg <= sample.motor_running;
        end
        if (advance)
            result_reg <= step_res;
    end

    assign result.valid            = result_valid_reg;
    assign result.electrical_angle = result_reg.electrical_angle;
    assign result.corrected_angle  = result_reg.corrected_angle;
    assign result.rotation_sense   = result_reg.rotation_sense;
    assign result.fault_code       = result_reg.fault_code;

`ifndef SYNTH
    a_advance_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid_reg)
        else $error("decoded sample did not reach the result register");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (s1_valid_reg && result_valid_reg && !result.ready))
        else $error("sample input stalled with a free stage");

    a_fault_gated: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && (result_reg.fault_code != FAULT_NONE))
            |-> (cfg_q.fault_enable && cfg_q.decode_enable))
        else $error("fault reported while faults or decoding disabled");
`endif

endmodule

@@ sim/hsad_checker.sv @@
// Checker for the Hall sector angle decoder: tracks configuration, predicts and compares results.
`timescale 1ns / 1ps

module hsad_checker
    import hsad_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hsad_in_if         sample,
    hsad_out_if        result,
    hsad_cfg_if        cfg,
    output int         fail_count,
    output int         results_pending
);

    cfg_t          settings;
    logic [15:0]   held_angle;
    logic [15:0]   out_angle;
    logic [15:0]   ref_angle;
    logic [15:0]   step_count;
    result_t       angle_queue[$];

    function automatic logic [15:0] hall_sector(input logic [2:0] code);
        int unsigned deg;
        case (code)
            3'd1:    deg = 330;
            3'd2:    deg = 210;
            3'd3:    deg = 270;
            3'd4:    deg = 90;
            3'd5:    deg = 30;
            default: deg = 150;
        endcase
        return 16'((deg * 65536) / 360);
    endfunction

    task automatic track_sample(input logic [2:0] code, input logic running,
                                output result_t r);
        logic [15:0] diff;
        int          delta;
        int          count;
        fault_t      flt;
        sense_t      sns;
        flt = FAULT_NONE;
        if (settings.decode_enable)
        begin
            if (code != HALL_LOGIC_FAULT && code != HALL_WIRING_FAULT)
                held_angle = hall_sector(code);
            else if (running && settings.fault_enable)
                flt = (code == HALL_WIRING_FAULT) ? FAULT_WIRING : FAULT_LOGIC;
            out_angle = settings.invert_direction ? 16'd0 - held_angle : held_angle;
        end
        diff  = out_angle - ref_angle;
        delta = $signed(diff);
        count = $signed(step_count);
        if (delta > DIR_THRESHOLD)
        begin
            if (count < COUNT_LIMIT)
                count++;
            ref_angle = out_angle;
        end
        else if (delta < -DIR_THRESHOLD)
        begin
            if (count > -COUNT_LIMIT)
                count--;
            ref_angle = out_angle;
        end
        step_count = count[15:0];
        if (count > SENSE_LIMIT)
            sns = SENSE_FORWARD;
        else if (count < -SENSE_LIMIT)
            sns = SENSE_BACKWARD;
        else
            sns = SENSE_UNKNOWN;
        r.electrical_angle = out_angle;
        r.corrected_angle  = out_angle + settings.zero_offset;
        r.rotation_sense   = sns;
        r.fault_code       = flt;
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got, inout int errors);
        if (want != got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t next_want;
        int      errors;
        if (!rst_n)
        begin
            settings        = '0;
            held_angle      = '0;
            out_angle       = '0;
            ref_angle       = '0;
            step_count      = '0;
            angle_queue.delete();
            fail_count      <= 0;
            results_pending <= 0;
        end
        else
        begin
            errors = 0;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_idx_t'(cfg.reg_index))
                    CFG_DECODE_ENABLE:    settings.decode_enable    = cfg.wdata[0];
                    CFG_INVERT_DIRECTION: settings.invert_direction = cfg.wdata[0];
                    CFG_FAULT_ENABLE:     settings.fault_enable     = cfg.wdata[0];
                    CFG_ZERO_OFFSET:      settings.zero_offset      = cfg.wdata;
                    default: ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                if (angle_queue.size() == 0)
                begin
                    $display("%0t: result with no sample outstanding, got angle %0d",
                             $time, result.electrical_angle);
                    errors++;
                end
                else
                begin
                    want = angle_queue.pop_front();
                    compare_field("electrical_angle", want.electrical_angle,
                                  result.electrical_angle, errors);
                    compare_field("corrected_angle", want.corrected_angle,
                                  result.corrected_angle, errors);
                    compare_field("rotation_sense", want.rotation_sense,
                                  result.rotation_sense, errors);
                    compare_field("fault_code", want.fault_code,
                                  result.fault_code, errors);
                end
            end
            if (sample.valid && sample.ready)
            begin
                track_sample(sample.hall_code, sample.motor_running, next_want);
                angle_queue.push_back(next_want);
            end
            fail_count      <= fail_count + errors;
            results_pending <= angle_queue.size();
        end
    end

endmodule

@@ sim/hall_sector_angle_direction_tb.sv @@
// Testbench top for the Hall sector angle decoder: stimulus, handshake idling and verdict.
`timescale 1ns / 1ps

module hall_sector_angle_direction_tb;
    import hsad_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 125;
    localparam int RANDOM_PHASES  = 8;

    logic clk;
    logic rst_n;
    logic steady;
    int   fail_count;
    int   results_pending;
    int   sample_xfers = 0;
    int   cfg_xfers    = 0;
    int   idle_cycles  = 0;
    int   stall_left   = 0;

    logic [2:0] rotation_order [6] = '{3'd5, 3'd4, 3'd6, 3'd2, 3'd3, 3'd1};

    hsad_in_if  sample_ch ();
    hsad_out_if result_ch ();
    hsad_cfg_if cfg_ch ();

    hall_sector_angle_direction dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    hsad_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample          (sample_ch),
        .result          (result_ch),
        .cfg             (cfg_ch),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
    begin
        if (sample_ch.valid && sample_ch.ready)
            sample_xfers <= sample_xfers + 1;
        if (cfg_ch.valid && cfg_ch.ready)
            cfg_xfers <= cfg_xfers + 1;
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= stall_left - 1;
        end
        else if (!steady && $urandom_range(0, 9) < 3)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= pick_gap();
        end
        else
            result_ch.ready <= 1'b1;
    end

    task automatic send_sample(input logic [2:0] code, input logic running);
        int gap;
        int seen;
        gap = steady ? 0 : pick_gap();
        if (gap != 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        seen = sample_xfers;
        sample_ch.hall_code     <= code;
        sample_ch.motor_running <= running;
        sample_ch.valid         <= 1'b1;
        do @(negedge clk); while (sample_xfers == seen);
    endtask

    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (results_pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apply_config(input cfg_t c);
        cfg_idx_t idx;
        int       seen;
        idx = idx.first();
        cfg_ch.valid <= 1'b1;
        repeat (4)
        begin
            seen = cfg_xfers;
            cfg_ch.reg_index <= idx;
            case (idx)
                CFG_DECODE_ENABLE:    cfg_ch.wdata <= {15'd0, c.decode_enable};
                CFG_INVERT_DIRECTION: cfg_ch.wdata <= {15'd0, c.invert_direction};
                CFG_FAULT_ENABLE:     cfg_ch.wdata <= {15'd0, c.fault_enable};
                default:              cfg_ch.wdata <= c.zero_offset;
            endcase
            do @(negedge clk); while (cfg_xfers == seen);
            idx = idx.next();
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic spin_burst(inout int sent);
        int pos;
        int step;
        int len;
        pos  = $urandom_range(0, 5);
        step = $urandom_range(0, 1) ? 1 : 5;
        len  = $urandom_range(8, 40);
        repeat (len)
        begin
            if ($urandom_range(0, 19) == 0)
                send_sample(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            else
            begin
                if ($urandom_range(0, 9) != 0)
                    pos = (pos + step) % 6;
                send_sample(rotation_order[pos], $urandom_range(0, 15) != 0);
            end
            sent++;
        end
    endtask

    initial
    begin
        cfg_t setting;
        int   sent;
        rst_n                   = 1'b0;
        steady                  = 1'b0;
        sample_ch.valid         = 1'b0;
        sample_ch.hall_code     = '0;
        sample_ch.motor_running = 1'b0;
        result_ch.ready         = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.reg_index        = CFG_DECODE_ENABLE;
        cfg_ch.wdata            = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // every code, fault gating, then a forward spin
        apply_config('{decode_enable: 1'b1, invert_direction: 1'b0,
                       fault_enable: 1'b1, zero_offset: 16'hFFFF});
        for (int c = 0; c < 8; c++)
            send_sample(3'(c), 1'b1);
        send_sample(HALL_LOGIC_FAULT, 1'b0);
        send_sample(HALL_WIRING_FAULT, 1'b0);
        foreach (rotation_order[i])
            send_sample(rotation_order[i], 1'b1);
        send_sample(rotation_order[0], 1'b1);
        settle();

        apply_config('{decode_enable: 1'b1, invert_direction: 1'b1,
                       fault_enable: 1'b0, zero_offset: 16'h0000});
        send_sample(HALL_WIRING_FAULT, 1'b1);
        send_sample(HALL_LOGIC_FAULT, 1'b1);
        for (int i = 5; i >= 2; i--)
            send_sample(rotation_order[i], 1'b1);
        settle();

        apply_config('{decode_enable: 1'b0, invert_direction: 1'b0,
                       fault_enable: 1'b1, zero_offset: 16'h8000});
        send_sample(3'd3, 1'b1);
        send_sample(HALL_LOGIC_FAULT, 1'b1);
        settle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            setting.decode_enable    = $urandom_range(0, 19) != 0;
            setting.invert_direction = 1'($urandom_range(0, 1));
            setting.fault_enable     = 1'($urandom_range(0, 1));
            case (ph)
                0:       setting.zero_offset = 16'h0000;
                1:       setting.zero_offset = 16'hFFFF;
                default: setting.zero_offset = 16'($urandom);
            endcase
            if (ph == 4)
                setting.decode_enable = 1'b0;
            apply_config(setting);
            steady = (ph == 3);
            sent   = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 75)
                    spin_burst(sent);
                else
                begin
                    send_sample(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
                    sent++;
                end
            end
            settle();
        end
        steady = 1'b0;

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
